### hw/rtl/btsl_pkg.sv
package btsl_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int CADDR_W  = 24;
    localparam int TARGET_W = 4;
    localparam int CORE_W   = 8;
    localparam int WCNT_W   = 30;
    localparam int CIDX_W   = 3;

    // address decode
    localparam logic [CADDR_W-1:0] CORE_ADDR_MASK = 24'hFF_FFFF;
    localparam logic [7:0]         SHARED_TOP     = 8'h0C;
    localparam logic [3:0]         LOCAL_ALIAS_HI = 4'h1;
    localparam logic [WORD_W-1:0]  SIZE_SAT_LIMIT = 32'hFFFF_FFFC;
    localparam logic [WCNT_W-1:0]  WORDS_MAX      = 30'h3FFF_FFFF;

    // target codes
    localparam logic [TARGET_W-1:0] TARGET_CORE0    = 4'd0;
    localparam logic [TARGET_W-1:0] TARGET_SHARED   = 4'd8;
    localparam logic [TARGET_W-1:0] TARGET_EXTERNAL = 4'd9;
    localparam logic [CORE_W-1:0]   CORE_COUNT      = 8'd8;

    // register reset values
    localparam logic [CORE_W-1:0]  TARGET_CORE_RST    = 8'h00;
    localparam logic [CADDR_W-1:0] LOCAL_START_RST    = 24'h80_0000;
    localparam logic [WORD_W-1:0]  SHARED_START_RST   = 32'h0C00_0000;
    localparam logic [WORD_W-1:0]  EXTERNAL_START_RST = 32'h8000_0000;
    localparam logic [WORD_W-1:0]  ENTRY_SLOT_RST     = 32'h0000_0000;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_TARGET_CORE    = 3'd0,
        REG_LOCAL_START    = 3'd1,
        REG_SHARED_START   = 3'd2,
        REG_EXTERNAL_START = 3'd3,
        REG_ENTRY_SLOT     = 3'd4
    } reg_index_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_ENTRY = 4'b0001,
        PH_SIZE  = 4'b0010,
        PH_ADDR  = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    // pending write between parser and offset stage
    typedef struct packed {
        logic [TARGET_W-1:0] tgt;
        logic [WORD_W-1:0]   addr;
        logic [WORD_W-1:0]   data;
        logic                is_entry;
    } emit_t;

endpackage

### hw/rtl/boot_table_section_loader_unit.sv
// channel   | beat contents                                   | handshake
// ----------+-------------------------------------------------+----------------------
// input     | image_byte                                      | in_valid / in_ready
// output    | target, byte_offset, data_word, dropped,        | out_valid / out_ready
//           | entry_write                                     |
// config    | cfg_index, cfg_data                             | cfg_we, no wait
//
// one byte per cycle while in_ready is high; writes pass the pending and result stages
// stages: parser registers, pending write register, result register
// reset returns every config register to its default and the parser to the entry phase
// a stalled result holds; once the pending write is also full, input waits until it moves on
module boot_table_section_loader_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [btsl_pkg::BYTE_W-1:0]       image_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [btsl_pkg::TARGET_W-1:0]     target,
    output logic [btsl_pkg::WORD_W-1:0]       byte_offset,
    output logic [btsl_pkg::WORD_W-1:0]       data_word,
    output logic                              dropped,
    output logic                              entry_write,
    input  logic                              cfg_we,
    input  logic [btsl_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [btsl_pkg::WORD_W-1:0]       cfg_data
);
    import btsl_pkg::*;

    // config registers
    logic [CORE_W-1:0]  target_core_reg;
    logic [CADDR_W-1:0] local_start_reg;
    logic [WORD_W-1:0]  shared_start_reg;
    logic [WORD_W-1:0]  external_start_reg;
    logic [WORD_W-1:0]  entry_slot_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [1:0]          byte_index_reg, byte_index_next;
    logic [CADDR_W-1:0]  partial_reg, partial_next;
    logic [WORD_W-1:0]   entry_addr_reg, entry_addr_next;
    logic [WCNT_W-1:0]   words_left_reg, words_left_next;
    logic [WORD_W-1:0]   write_addr_reg, write_addr_next;
    logic [TARGET_W-1:0] sect_target_reg, sect_target_next;

    // pending write stage
    logic  pend_valid_reg;
    emit_t pend_reg;
    emit_t emit_next;
    logic  emit_fire;

    // result stage
    logic                out_valid_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [WORD_W-1:0]   offset_reg, offset_next;
    logic [WORD_W-1:0]   data_reg;
    logic                dropped_reg, dropped_next;
    logic                entry_reg;

    logic                in_accept;
    logic                out_load;
    logic [WORD_W-1:0]   word;
    logic [7:0]          top_byte;
    logic [WCNT_W-1:0]   words_dec;
    logic [WORD_W-1:0]   eff_addr;
    logic [WORD_W-1:0]   region_start;

    // handshake
    assign out_load  = !out_valid_reg || out_ready;
    assign in_ready  = !pend_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_core_reg    <= TARGET_CORE_RST;
            local_start_reg    <= LOCAL_START_RST;
            shared_start_reg   <= SHARED_START_RST;
            external_start_reg <= EXTERNAL_START_RST;
            entry_slot_reg     <= ENTRY_SLOT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_CORE:    target_core_reg    <= cfg_data[CORE_W-1:0];
                REG_LOCAL_START:    local_start_reg    <= cfg_data[CADDR_W-1:0];
                REG_SHARED_START:   shared_start_reg   <= cfg_data;
                REG_EXTERNAL_START: external_start_reg <= cfg_data;
                REG_ENTRY_SLOT:     entry_slot_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // byte assembly and section parsing
    assign word      = {partial_reg, image_byte};
    assign top_byte  = word[WORD_W-1 -: 8];
    assign words_dec = (words_left_reg != '0) ? words_left_reg - 1'b1 : words_left_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        partial_next     = partial_reg;
        entry_addr_next  = entry_addr_reg;
        words_left_next  = words_left_reg;
        write_addr_next  = write_addr_reg;
        sect_target_next = sect_target_reg;
        emit_fire        = 1'b0;
        emit_next        = '{tgt: sect_target_reg, addr: write_addr_reg,
                             data: word, is_entry: 1'b0};
        if (in_accept)
        begin
            if (byte_index_reg != 2'd3)
            begin
                partial_next    = {partial_reg[CADDR_W-9:0], image_byte};
                byte_index_next = byte_index_reg + 2'd1;
            end
            else
            begin
                partial_next    = '0;
                byte_index_next = 2'd0;
                unique case (phase_reg)
                    PH_ENTRY:
                    begin
                        entry_addr_next = word;
                        phase_next      = PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        if (word == '0)
                        begin
                            emit_fire  = 1'b1;
                            emit_next  = '{tgt: TARGET_CORE0, addr: entry_slot_reg,
                                           data: entry_addr_reg, is_entry: 1'b1};
                            phase_next = PH_ENTRY;
                        end
                        else
                        begin
                            // round up to whole words, saturate near the top
                            if (word > SIZE_SAT_LIMIT)
                                words_left_next = WORDS_MAX;
                            else
                                words_left_next = word[WORD_W-1:2]
                                                + {{(WCNT_W-1){1'b0}}, |word[1:0]};
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        write_addr_next = word;
                        // region chosen once per section from the top byte
                        priority if (top_byte == 8'h00 || top_byte[7:4] == LOCAL_ALIAS_HI[3:0])
                            sect_target_next = (target_core_reg < CORE_COUNT)
                                             ? target_core_reg[TARGET_W-1:0] : TARGET_CORE0;
                        else if (top_byte == SHARED_TOP)
                            sect_target_next = TARGET_SHARED;
                        else
                            sect_target_next = TARGET_EXTERNAL;
                        phase_next = (words_left_reg == '0) ? PH_SIZE : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        emit_fire       = 1'b1;
                        write_addr_next = write_addr_reg + WORD_W'(4);
                        words_left_next = words_dec;
                        if (words_dec == '0)
                            phase_next = PH_SIZE;
                    end
                    default:
                        phase_next = PH_ENTRY;
                endcase
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_ENTRY;
            byte_index_reg  <= 2'd0;
            partial_reg     <= '0;
            entry_addr_reg  <= '0;
            words_left_reg  <= '0;
            write_addr_reg  <= '0;
            sect_target_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            partial_reg     <= partial_next;
            entry_addr_reg  <= entry_addr_next;
            words_left_reg  <= words_left_next;
            write_addr_reg  <= write_addr_next;
            sect_target_reg <= sect_target_next;
        end
    end

    // pending write register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (in_ready)
            pend_valid_reg <= in_accept && emit_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit_fire)
            pend_reg <= emit_next;
    end

    // region offset and below-start check
    always_comb
    begin
        if (pend_reg.tgt < TARGET_SHARED)
        begin
            eff_addr     = {8'h00, pend_reg.addr[CADDR_W-1:0] & CORE_ADDR_MASK};
            region_start = {8'h00, local_start_reg};
        end
        else if (pend_reg.tgt == TARGET_SHARED)
        begin
            eff_addr     = pend_reg.addr;
            region_start = shared_start_reg;
        end
        else
        begin
            eff_addr     = pend_reg.addr;
            region_start = external_start_reg;
        end
        dropped_next = eff_addr < region_start;
        offset_next  = dropped_next ? '0 : eff_addr - region_start;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= pend_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && pend_valid_reg)
        begin
            target_reg  <= pend_reg.tgt;
            offset_reg  <= offset_next;
            data_reg    <= pend_reg.data;
            dropped_reg <= dropped_next;
            entry_reg   <= pend_reg.is_entry;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = target_reg;
    assign byte_offset = offset_reg;
    assign data_word   = data_reg;
    assign dropped     = dropped_reg;
    assign entry_write = entry_reg;

endmodule

### hw/rtl/btsl_checker.sv
module btsl_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [btsl_pkg::TARGET_W-1:0]     target,
    input  logic [btsl_pkg::WORD_W-1:0]       byte_offset,
    input  logic [btsl_pkg::WORD_W-1:0]       data_word,
    input  logic                              dropped,
    input  logic                              entry_write
);
    import btsl_pkg::*;

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target) && $stable(byte_offset)
                                    && $stable(data_word) && $stable(dropped)
                                    && $stable(entry_write))
        else $error("result beat changed while stalled");

    // only core, shared or external targets
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target <= TARGET_EXTERNAL)
        else $error("target code out of range");

    // a discarded write carries a zero offset
    a_drop_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> byte_offset == '0)
        else $error("dropped write with nonzero offset");

    // the entry write always goes to core 0
    a_entry_core0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_write |-> target == TARGET_CORE0)
        else $error("entry write not aimed at core 0");

endmodule

bind boot_table_section_loader_unit btsl_checker u_btsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .target      (target),
    .byte_offset (byte_offset),
    .data_word   (data_word),
    .dropped     (dropped),
    .entry_write (entry_write)
);
